[src/tlr_pkg.sv]
// ----------------------------------------------------------------------------
// tlr_pkg
// Shared types, constants and helpers for the thick line rasteriser.
// ----------------------------------------------------------------------------
package tlr_pkg;

  localparam int COORD_W = 14;
  localparam int DELTA_W = 15;
  localparam int ERR_W   = 17;
  localparam int OFS_W   = 4;
  localparam int RAD_W   = 3;
  localparam int DIM_W   = 13;
  localparam int PIX_W   = 12;
  localparam int CHAN_W  = 8;

  localparam logic [DIM_W-1:0] MAX_DIM     = 13'd4096;
  localparam logic [DIM_W-1:0] WIDTH_RESET = 13'd1024;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd1024;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic REG_MAP_WIDTH  = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  typedef struct packed {
    logic                      cmd;
    logic signed [COORD_W-1:0] x_start;
    logic signed [COORD_W-1:0] y_start;
    logic signed [COORD_W-1:0] x_end;
    logic signed [COORD_W-1:0] y_end;
    logic [RAD_W-1:0]          radius;
    logic [CHAN_W-1:0]         red;
    logic [CHAN_W-1:0]         green;
    logic [CHAN_W-1:0]         blue;
  } tlr_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel_x;
    logic [PIX_W-1:0]  pixel_y;
    logic              write_enable;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              last;
  } tlr_pixel_t;

  // True when the offset lies inside the disc of the given radius.
  function automatic logic disc_inside(input logic signed [OFS_W-1:0] ox,
                                       input logic signed [OFS_W-1:0] oy,
                                       input logic [RAD_W-1:0] r);
    logic [2*OFS_W-1:0] sq_x;
    logic [2*OFS_W-1:0] sq_y;
    logic [2*OFS_W:0]   sum;
    logic [2*RAD_W-1:0] sq_r;
    // The low bits of a product of sign-extended operands are the true square.
    sq_x = {{OFS_W{ox[OFS_W-1]}}, ox} * {{OFS_W{ox[OFS_W-1]}}, ox};
    sq_y = {{OFS_W{oy[OFS_W-1]}}, oy} * {{OFS_W{oy[OFS_W-1]}}, oy};
    sum  = {1'b0, sq_x} + {1'b0, sq_y};
    sq_r = {{RAD_W{1'b0}}, r} * {{RAD_W{1'b0}}, r};
    return sum <= {3'b000, sq_r};
  endfunction

endpackage

[src/tlr_walker.sv]
// ----------------------------------------------------------------------------
// tlr_walker
// Line state, disc offset counters and the per-step pixel computation.
// ----------------------------------------------------------------------------
module tlr_walker (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     take,
  input  tlr_pkg::tlr_item_t       item,
  input  logic [tlr_pkg::DIM_W-1:0] wmax,
  input  logic [tlr_pkg::DIM_W-1:0] hmax,
  output tlr_pkg::tlr_pixel_t      result
);
  import tlr_pkg::*;

  logic                      active;
  logic signed [COORD_W-1:0] cur_x, cur_y, end_x, end_y;
  logic [DELTA_W-1:0]        delta_x, delta_y;
  logic                      step_x_neg, step_y_neg;
  logic signed [ERR_W-1:0]   error_term;
  logic signed [OFS_W-1:0]   offset_x, offset_y;
  logic [RAD_W-1:0]          brush_radius;
  logic [3*CHAN_W-1:0]       colour;

  logic                      active_next;
  logic signed [COORD_W-1:0] cur_x_next, cur_y_next;
  logic signed [ERR_W-1:0]   error_term_next;
  logic signed [OFS_W-1:0]   offset_x_next, offset_y_next;

  logic signed [DELTA_W-1:0] diff_x, diff_y;
  logic [DELTA_W-1:0]        abs_x, abs_y;

  logic signed [OFS_W-1:0]   rad_s;
  logic signed [COORD_W:0]   pos_x, pos_y;
  logic                      in_map, in_disc, write_ok, at_end, disc_done;
  logic signed [ERR_W:0]     e2;
  logic                      move_x, move_y;
  logic signed [ERR_W-1:0]   err_sub, err_add;

  // Start item set-up.
  always_comb begin
    diff_x = {item.x_end[COORD_W-1], item.x_end} - {item.x_start[COORD_W-1], item.x_start};
    diff_y = {item.y_end[COORD_W-1], item.y_end} - {item.y_start[COORD_W-1], item.y_start};
    abs_x  = diff_x[DELTA_W-1] ? DELTA_W'(-diff_x) : DELTA_W'(diff_x);
    abs_y  = diff_y[DELTA_W-1] ? DELTA_W'(-diff_y) : DELTA_W'(diff_y);
  end

  // Candidate pixel for the current disc position.
  always_comb begin
    rad_s     = $signed({1'b0, brush_radius});
    pos_x     = {cur_x[COORD_W-1], cur_x} + {{(COORD_W+1-OFS_W){offset_x[OFS_W-1]}}, offset_x};
    pos_y     = {cur_y[COORD_W-1], cur_y} + {{(COORD_W+1-OFS_W){offset_y[OFS_W-1]}}, offset_y};
    in_map    = !pos_x[COORD_W] && !pos_y[COORD_W]
                && (pos_x[COORD_W-1:0] < {1'b0, wmax})
                && (pos_y[COORD_W-1:0] < {1'b0, hmax});
    in_disc   = disc_inside(offset_x, offset_y, brush_radius);
    write_ok  = active && in_map && in_disc;
    at_end    = (cur_x == end_x) && (cur_y == end_y);
    disc_done = (offset_x >= rad_s) && (offset_y >= rad_s);

    result.write_enable = write_ok;
    result.pixel_x      = write_ok ? pos_x[PIX_W-1:0] : '0;
    result.pixel_y      = write_ok ? pos_y[PIX_W-1:0] : '0;
    result.red          = colour[3*CHAN_W-1:2*CHAN_W];
    result.green        = colour[2*CHAN_W-1:CHAN_W];
    result.blue         = colour[CHAN_W-1:0];
    result.last         = !active || (at_end && disc_done);
  end

  // Advance: offsets run row by row, then one Bresenham step.
  always_comb begin
    e2      = {error_term, 1'b0};
    move_x  = e2 > -$signed({3'b000, delta_y});
    move_y  = e2 < $signed({3'b000, delta_x});
    err_sub = move_x ? $signed({2'b00, delta_y}) : '0;
    err_add = move_y ? $signed({2'b00, delta_x}) : '0;

    active_next     = active;
    cur_x_next      = cur_x;
    cur_y_next      = cur_y;
    error_term_next = error_term;
    offset_x_next   = offset_x;
    offset_y_next   = offset_y;

    if (active) begin
      if (offset_x < rad_s) begin
        offset_x_next = offset_x + 4'sd1;
      end else begin
        offset_x_next = -rad_s;
        if (offset_y < rad_s) begin
          offset_y_next = offset_y + 4'sd1;
        end else begin
          offset_y_next = -rad_s;
          if (at_end) begin
            active_next = 1'b0;
          end else begin
            error_term_next = error_term - err_sub + err_add;
            if (move_x) begin
              cur_x_next = step_x_neg ? cur_x - 14'sd1 : cur_x + 14'sd1;
            end
            if (move_y) begin
              cur_y_next = step_y_neg ? cur_y - 14'sd1 : cur_y + 14'sd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      cur_x        <= '0;
      cur_y        <= '0;
      end_x        <= '0;
      end_y        <= '0;
      delta_x      <= '0;
      delta_y      <= '0;
      step_x_neg   <= 1'b0;
      step_y_neg   <= 1'b0;
      error_term   <= '0;
      offset_x     <= '0;
      offset_y     <= '0;
      brush_radius <= '0;
      colour       <= '0;
    end else if (take && item.cmd == CMD_START) begin
      active       <= 1'b1;
      cur_x        <= item.x_start;
      cur_y        <= item.y_start;
      end_x        <= item.x_end;
      end_y        <= item.y_end;
      delta_x      <= abs_x;
      delta_y      <= abs_y;
      // Step is negative unless the end lies strictly above the start.
      step_x_neg   <= diff_x[DELTA_W-1] || (diff_x == '0);
      step_y_neg   <= diff_y[DELTA_W-1] || (diff_y == '0);
      error_term   <= $signed({2'b00, abs_x}) - $signed({2'b00, abs_y});
      brush_radius <= item.radius;
      offset_x     <= -$signed({1'b0, item.radius});
      offset_y     <= -$signed({1'b0, item.radius});
      colour       <= {item.red, item.green, item.blue};
    end else if (take && item.cmd == CMD_STEP) begin
      active       <= active_next;
      cur_x        <= cur_x_next;
      cur_y        <= cur_y_next;
      error_term   <= error_term_next;
      offset_x     <= offset_x_next;
      offset_y     <= offset_y_next;
    end
  end

endmodule

[src/tlr_out_stage.sv]
// ----------------------------------------------------------------------------
// tlr_out_stage
// Result register with valid/stall handshake towards the pixel sink.
// ----------------------------------------------------------------------------
module tlr_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  tlr_pkg::tlr_pixel_t result,
  input  logic                out_stall,
  output logic                out_valid,
  output logic                busy,
  output tlr_pkg::tlr_pixel_t held
);
  import tlr_pkg::*;

  // A new result may enter whenever the held one leaves in the same cycle.
  assign busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

[src/thick_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// thick_line_rasterizer
// Bresenham line walker stamping a clipped filled disc at every line point.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  input    | in_valid / in_stall   | cmd, endpoints, radius, colour
//  output   | out_valid / out_stall | pixel_x, pixel_y, write_enable, colour,
//           |                       | last
//  config   | cfg_write             | cfg_index, cfg_data
//
//  One item is taken per cycle while not stalled; a step transfer gives its pixel
//  in the next cycle. A start transfer gives no pixel. Reset is synchronous and
//  returns the block to idle with a 1024 by 1024 map. Input stall is raised only
//  while a result waits in the output register and the sink stalls it.
// ----------------------------------------------------------------------------
module thick_line_rasterizer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                cmd,
  input  logic signed [tlr_pkg::COORD_W-1:0]  x_start,
  input  logic signed [tlr_pkg::COORD_W-1:0]  y_start,
  input  logic signed [tlr_pkg::COORD_W-1:0]  x_end,
  input  logic signed [tlr_pkg::COORD_W-1:0]  y_end,
  input  logic [tlr_pkg::RAD_W-1:0]           radius,
  input  logic [tlr_pkg::CHAN_W-1:0]          red_in,
  input  logic [tlr_pkg::CHAN_W-1:0]          green_in,
  input  logic [tlr_pkg::CHAN_W-1:0]          blue_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tlr_pkg::PIX_W-1:0]           pixel_x,
  output logic [tlr_pkg::PIX_W-1:0]           pixel_y,
  output logic                                write_enable,
  output logic [tlr_pkg::CHAN_W-1:0]          red_out,
  output logic [tlr_pkg::CHAN_W-1:0]          green_out,
  output logic [tlr_pkg::CHAN_W-1:0]          blue_out,
  output logic                                last,
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [tlr_pkg::DIM_W-1:0]           cfg_data
);
  import tlr_pkg::*;

  logic [DIM_W-1:0] map_width;
  logic [DIM_W-1:0] map_height;
  logic [DIM_W-1:0] wmax;
  logic [DIM_W-1:0] hmax;
  logic             take;
  tlr_item_t        item;
  tlr_pixel_t       result;
  tlr_pixel_t       held;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= WIDTH_RESET;
      map_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAP_WIDTH:  map_width  <= cfg_data;
        REG_MAP_HEIGHT: map_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sizes beyond the largest map act as the largest map.
  assign wmax = (map_width > MAX_DIM) ? MAX_DIM : map_width;
  assign hmax = (map_height > MAX_DIM) ? MAX_DIM : map_height;

  assign take = in_valid && !in_stall;

  always_comb begin
    item.cmd     = cmd;
    item.x_start = x_start;
    item.y_start = y_start;
    item.x_end   = x_end;
    item.y_end   = y_end;
    item.radius  = radius;
    item.red     = red_in;
    item.green   = green_in;
    item.blue    = blue_in;
  end

  tlr_walker u_walker (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .item   (item),
    .wmax   (wmax),
    .hmax   (hmax),
    .result (result)
  );

  tlr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take && cmd == CMD_STEP),
    .result    (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .busy      (in_stall),
    .held      (held)
  );

  assign pixel_x      = held.pixel_x;
  assign pixel_y      = held.pixel_y;
  assign write_enable = held.write_enable;
  assign red_out      = held.red;
  assign green_out    = held.green;
  assign blue_out     = held.blue;
  assign last         = held.last;

`ifndef SYNTHESIS
  a_step_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && cmd == CMD_STEP) |=> out_valid)
    else $error("step transfer did not produce a result");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a waiting result");

  a_write_in_map: assert property (@(posedge clk) disable iff (rst)
    (out_valid && write_enable) |-> (({1'b0, pixel_x} < wmax) && ({1'b0, pixel_y} < hmax)))
    else $error("pixel write outside the map");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !write_enable) |-> (pixel_x == '0 && pixel_y == '0))
    else $error("pixel coordinates not cleared without a write");
`endif

endmodule

[sim/thick_line_rasterizer_test.sv]
// ----------------------------------------------------------------------------
// thick_line_rasterizer_test
// Self-checking bench for the thick line rasteriser. A directed table covers
// idle steps, the coordinate and radius extremes, a restart part-way through a
// walk, and clipping at both map edges. Random phases follow, each under its
// own map size, and are made mostly of complete line walks near the map edges.
// Every pixel transfer is checked against a typed expectation or a cycle-free walk model.
// ----------------------------------------------------------------------------
module thick_line_rasterizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tlr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    tlr_item_t  item;
    logic       typed;
    tlr_pixel_t want;
  } directed_row_t;

  localparam tlr_item_t STEP_ITEM = '{cmd: CMD_STEP, default: '0};
  localparam tlr_pixel_t NO_PIXEL = '0;

  localparam directed_row_t DIRECTED[17] = '{
    // Step straight after reset: nothing to draw, stored colour is zero.
    '{STEP_ITEM, 1'b1, '{12'd0, 12'd0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1}},
    '{'{CMD_START, 14'sd0, 14'sd0, 14'sd0, 14'sd0, 3'd0, 8'hff, 8'h00, 8'h80},
      1'b0, NO_PIXEL},
    '{STEP_ITEM, 1'b1, '{12'd0, 12'd0, 1'b1, 8'hff, 8'h00, 8'h80, 1'b1}},
    '{STEP_ITEM, 1'b1, '{12'd0, 12'd0, 1'b0, 8'hff, 8'h00, 8'h80, 1'b1}},
    // Corner to corner of the coordinate space, widest brush (14'sh2000 is -8192).
    '{'{CMD_START, 14'sh2000, 14'sd8191, 14'sd8191, 14'sh2000, 3'd7, 8'h00, 8'hff,
        8'h7f}, 1'b0, NO_PIXEL},
    '{STEP_ITEM, 1'b0, NO_PIXEL},
    '{STEP_ITEM, 1'b0, NO_PIXEL},
    '{STEP_ITEM, 1'b0, NO_PIXEL},
    // Restart while the long walk is still active; the first point is off map.
    '{'{CMD_START, -14'sd1, -14'sd1, 14'sd1, 14'sd1, 3'd0, 8'h12, 8'h34, 8'h56},
      1'b0, NO_PIXEL},
    '{STEP_ITEM, 1'b1, '{12'd0, 12'd0, 1'b0, 8'h12, 8'h34, 8'h56, 1'b0}},
    '{STEP_ITEM, 1'b0, NO_PIXEL},
    '{STEP_ITEM, 1'b0, NO_PIXEL},
    // Diagonal across the far corner of the reset map, clipped at both ends.
    '{'{CMD_START, 14'sd1024, 14'sd1021, 14'sd1021, 14'sd1024, 3'd0, 8'hff, 8'hff,
        8'hff}, 1'b0, NO_PIXEL},
    '{STEP_ITEM, 1'b0, NO_PIXEL},
    '{STEP_ITEM, 1'b0, NO_PIXEL},
    '{STEP_ITEM, 1'b0, NO_PIXEL},
    '{STEP_ITEM, 1'b0, NO_PIXEL}
  };

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic cmd = CMD_START;
  logic signed [COORD_W-1:0] x_start = '0;
  logic signed [COORD_W-1:0] y_start = '0;
  logic signed [COORD_W-1:0] x_end = '0;
  logic signed [COORD_W-1:0] y_end = '0;
  logic [RAD_W-1:0] radius = '0;
  logic [CHAN_W-1:0] red_in = '0;
  logic [CHAN_W-1:0] green_in = '0;
  logic [CHAN_W-1:0] blue_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;
  logic write_enable;
  logic [CHAN_W-1:0] red_out;
  logic [CHAN_W-1:0] green_out;
  logic [CHAN_W-1:0] blue_out;
  logic last;
  logic cfg_write = 1'b0;
  logic cfg_index = REG_MAP_WIDTH;
  logic [DIM_W-1:0] cfg_data = '0;

  // Travels with the item on the input channel: a typed-in expectation.
  logic item_typed = 1'b0;
  tlr_pixel_t item_want = '0;

  int cycle_count = 0;
  int failures = 0;
  int gap_odds = 1;
  bit quiet = 1'b0;
  bit hold_request = 1'b0;

  // Line walk model state.
  logic [DIM_W-1:0] map_w;
  logic [DIM_W-1:0] map_h;
  bit walk_active;
  int walk_x, walk_y, goal_x, goal_y;
  int span_x, span_y, bres_err;
  bit dir_x_neg, dir_y_neg;
  int disc_ox, disc_oy, disc_r;
  logic [3*CHAN_W-1:0] line_rgb;
  tlr_pixel_t pending_pixels[$];

  thick_line_rasterizer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .x_start(x_start), .y_start(y_start), .x_end(x_end), .y_end(y_end),
    .radius(radius), .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .write_enable(write_enable),
    .red_out(red_out), .green_out(green_out), .blue_out(blue_out), .last(last),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("thick_line_rasterizer_test NOT OK");
      $finish;
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  // Advances the line walk by one accepted item and queues the pixel it gives.
  task automatic rasterize_item(input tlr_item_t it, input logic typed,
                                input tlr_pixel_t typed_px);
    int ox, oy, r, px, py, wmax, hmax, e2;
    bit at_end, disc_done;
    tlr_pixel_t res;
    if (it.cmd == CMD_START) begin
      walk_x = it.x_start;
      walk_y = it.y_start;
      goal_x = it.x_end;
      goal_y = it.y_end;
      span_x = goal_x > walk_x ? goal_x - walk_x : walk_x - goal_x;
      span_y = goal_y > walk_y ? goal_y - walk_y : walk_y - goal_y;
      dir_x_neg = !(walk_x < goal_x);
      dir_y_neg = !(walk_y < goal_y);
      bres_err = span_x - span_y;
      disc_r = int'(it.radius);
      disc_ox = -disc_r;
      disc_oy = -disc_r;
      line_rgb = {it.red, it.green, it.blue};
      walk_active = 1'b1;
    end else begin
      res = '0;
      res.last = 1'b1;
      {res.red, res.green, res.blue} = line_rgb;
      if (walk_active) begin
        wmax = map_w > MAX_DIM ? int'(MAX_DIM) : int'(map_w);
        hmax = map_h > MAX_DIM ? int'(MAX_DIM) : int'(map_h);
        ox = disc_ox;
        oy = disc_oy;
        r = disc_r;
        px = walk_x + ox;
        py = walk_y + oy;
        at_end = walk_x == goal_x && walk_y == goal_y;
        disc_done = ox >= r && oy >= r;
        if (ox * ox + oy * oy <= r * r && px >= 0 && py >= 0 && px < wmax && py < hmax) begin
          res.write_enable = 1'b1;
          res.pixel_x = px[PIX_W-1:0];
          res.pixel_y = py[PIX_W-1:0];
        end
        res.last = at_end && disc_done;
        if (ox < r) begin
          disc_ox = ox + 1;
        end else begin
          disc_ox = -r;
          if (oy < r) begin
            disc_oy = oy + 1;
          end else begin
            disc_oy = -r;
            if (at_end) begin
              walk_active = 1'b0;
            end else begin
              e2 = 2 * bres_err;
              if (e2 > -span_y) begin
                bres_err -= span_y;
                walk_x += dir_x_neg ? -1 : 1;
              end
              if (e2 < span_x) begin
                bres_err += span_x;
                walk_y += dir_y_neg ? -1 : 1;
              end
            end
          end
        end
      end
      pending_pixels.push_back(typed ? typed_px : res);
    end
  endtask

  always @(posedge clk) begin
    tlr_item_t seen;
    tlr_pixel_t due;
    if (rst) begin
      map_w = WIDTH_RESET;
      map_h = HEIGHT_RESET;
      walk_active = 1'b0;
      walk_x = 0; walk_y = 0; goal_x = 0; goal_y = 0;
      span_x = 0; span_y = 0; bres_err = 0;
      dir_x_neg = 1'b0; dir_y_neg = 1'b0;
      disc_ox = 0; disc_oy = 0; disc_r = 0;
      line_rgb = '0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_MAP_WIDTH) map_w = cfg_data;
        else map_h = cfg_data;
      end
      // Results are checked before the new item is modelled: the pixel leaving
      // now always belongs to an earlier transfer.
      if (out_valid && !out_stall) begin
        if (pending_pixels.size() == 0) begin
          $error("pixel transfer with no pixel pending");
          failures++;
        end else begin
          due = pending_pixels.pop_front();
          check_field("pixel_x", due.pixel_x, pixel_x);
          check_field("pixel_y", due.pixel_y, pixel_y);
          check_field("write_enable", due.write_enable, write_enable);
          check_field("red_out", due.red, red_out);
          check_field("green_out", due.green, green_out);
          check_field("blue_out", due.blue, blue_out);
          check_field("last", due.last, last);
        end
      end
      if (in_valid && !in_stall) begin
        seen = '{cmd, x_start, y_start, x_end, y_end, radius, red_in, green_in, blue_in};
        rasterize_item(seen, item_typed, item_want);
      end
    end
  end

  // Output side: random stall bursts, free stretches, and one long hold-off.
  initial begin
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b0;
        repeat (quiet ? 1 : $urandom_range(1, 40)) @(negedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input tlr_item_t it, input logic typed, input tlr_pixel_t want);
    if (!quiet && gap_odds != 0 && $urandom_range(0, 3) < gap_odds) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= it.cmd;
    x_start <= it.x_start;
    y_start <= it.y_start;
    x_end <= it.x_end;
    y_end <= it.y_end;
    radius <= it.radius;
    red_in <= it.red;
    green_in <= it.green;
    blue_in <= it.blue;
    item_typed <= typed;
    item_want <= want;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // The map is only reconfigured once every pixel has left the block.
  task automatic set_map(input int w, input int h);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_MAP_WIDTH;
    cfg_data <= DIM_W'(w);
    @(negedge clk);
    cfg_index <= REG_MAP_HEIGHT;
    cfg_data <= DIM_W'(h);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // A coordinate close to the low edge, close to the high edge, or inside the map.
  function automatic int near_edge(input int lim);
    case ($urandom_range(0, 2))
      0: return int'($urandom_range(0, 6)) - 3;
      1: return lim - 4 + int'($urandom_range(0, 7));
      default: return lim > 1 ? int'($urandom_range(0, lim - 1)) : 0;
    endcase
  endfunction

  task automatic run_phase(input int budget);
    int used, wclip, hclip, pick, span, r, n_steps, walk_len, xs, ys, xe, ye, dx, dy;
    tlr_item_t it;
    used = 0;
    wclip = map_w > MAX_DIM ? int'(MAX_DIM) : int'(map_w);
    hclip = map_h > MAX_DIM ? int'(MAX_DIM) : int'(map_h);
    while (used < budget) begin
      gap_odds = $urandom_range(0, 2);
      it = '0;
      it.cmd = CMD_START;
      it.red = CHAN_W'($urandom);
      it.green = CHAN_W'($urandom);
      it.blue = CHAN_W'($urandom);
      if ($urandom_range(0, 99) < 8) begin
        // Noise: a line anywhere in the coordinate space, abandoned early.
        it.x_start = COORD_W'($urandom);
        it.y_start = COORD_W'($urandom);
        it.x_end = COORD_W'($urandom);
        it.y_end = COORD_W'($urandom);
        it.radius = RAD_W'($urandom);
        n_steps = $urandom_range(0, 6);
      end else begin
        pick = $urandom_range(0, 19);
        r = pick < 11 ? 0 : pick < 17 ? 1 : pick < 19 ? 2 : int'($urandom_range(3, 7));
        span = r > 2 ? 0 : r == 2 ? 1 : r == 1 ? 3 : 6;
        xs = near_edge(wclip);
        ys = near_edge(hclip);
        xe = xs + int'($urandom_range(0, 2 * span)) - span;
        ye = ys + int'($urandom_range(0, 2 * span)) - span;
        dx = xe > xs ? xe - xs : xs - xe;
        dy = ye > ys ? ye - ys : ys - ye;
        walk_len = ((dx > dy ? dx : dy) + 1) * (2 * r + 1) * (2 * r + 1);
        it.x_start = COORD_W'(xs);
        it.y_start = COORD_W'(ys);
        it.x_end = COORD_W'(xe);
        it.y_end = COORD_W'(ye);
        it.radius = RAD_W'(r);
        // Mostly complete walks; some are cut short by the next start and some
        // run on into idle steps.
        pick = $urandom_range(0, 9);
        n_steps = pick == 0 ? int'($urandom_range(0, walk_len - 1)) :
                  walk_len + (pick == 1 ? int'($urandom_range(1, 3)) : 0);
      end
      send_item(it, 1'b0, NO_PIXEL);
      it.cmd = CMD_STEP;
      repeat (n_steps) send_item(it, 1'b0, NO_PIXEL);
      used += n_steps + 1;
    end
  endtask

  initial begin
    int k;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (DIRECTED[i]) send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);
    run_phase(70);

    set_map(4096, 4096);
    hold_request = 1'b1;
    run_phase(80);
    set_map(8191, 8191);
    run_phase(60);
    set_map(0, 4096);
    run_phase(50);
    set_map(4096, 0);
    run_phase(50);
    set_map(1, 1);
    run_phase(50);
    set_map(16, 4095);
    run_phase(80);
    set_map($urandom_range(1, 4096), $urandom_range(1, 4096));
    run_phase(100);
    set_map($urandom_range(0, 8191), $urandom_range(0, 8191));
    run_phase(80);

    // Final stretch runs at full rate on both sides.
    quiet = 1'b1;
    set_map(1024, 1024);
    run_phase(80);
    in_valid <= 1'b0;

    for (k = 0; k < 2000 && pending_pixels.size() != 0; k++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      $error("%0d pixels never left the block", pending_pixels.size());
      failures++;
    end
    if (failures == 0) begin
      $display("thick_line_rasterizer_test OK");
    end else begin
      $display("thick_line_rasterizer_test NOT OK");
    end
    $finish;
  end

endmodule
